FILE: hdl/erdr_pkg.sv
// Shared constants, widths and arithmetic helpers for the Euler dead-reckoning block.
package erdr_pkg;

  localparam int ANG_W = 15;
  localparam int VEL_W = 16;
  localparam int SEC_W = 32;
  localparam int NS_W = 30;
  localparam int ALT_W = 16;
  localparam int OUT_W = 44;

  localparam int TRIG_FRAC_BITS = 15;
  localparam longint MAX_STEP_NS = 2147483647;
  localparam int DT_W = 31;

  localparam int Q_W = TRIG_FRAC_BITS + 2;
  localparam int M_W = TRIG_FRAC_BITS + 3;
  localparam int GV_W = 20;

  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_W = 64;
  localparam int DVSR_W = 20;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_RADIX_BITS;

  localparam int TERMS = 5;

  localparam logic [15:0] TURN_UNITS = 16'd23040;
  localparam logic [15:0] QUARTER_UNITS = 16'd5760;
  localparam logic [DVSR_W-1:0] HALF_UNITS = 20'd11520;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;
  localparam logic [30:0] ROUND_Q = 31'd1 << (29 - TRIG_FRAC_BITS);
  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [DVSR_W-1:0] NS_PER_UM = 20'd1000000;

  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);
  localparam logic [DIV_W-1:0] OUT_POS = (64'd1 << (OUT_W - 1)) - 64'd1;

  // Round Q(2F) product to Q(F), half away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] mag;
    mag = -v;
    if (!v[PROD_W-1]) begin
      rnd_q = (v + RND_HALF) >>> TRIG_FRAC_BITS;
    end else begin
      rnd_q = -((mag + RND_HALF) >>> TRIG_FRAC_BITS);
    end
  endfunction

  // Clamp Q30 to one and round to Q(F).
  function automatic logic signed [Q_W-1:0] to_frac(input logic [30:0] x);
    logic [30:0] c;
    logic [30:0] s;
    c = (x > ONE_Q30) ? ONE_Q30 : x;
    s = (c + ROUND_Q) >> (30 - TRIG_FRAC_BITS);
    to_frac = Q_W'(s);
  endfunction

  // Taylor factorial ratios for the sine and cosine Horner chains.
  function automatic logic [DVSR_W-1:0] horner_div(input logic cos_ph, input logic [2:0] j);
    logic [3:0] sel;
    sel = {cos_ph, j};
    case (sel)
      4'd0: horner_div = DVSR_W'(110);
      4'd1: horner_div = DVSR_W'(72);
      4'd2: horner_div = DVSR_W'(42);
      4'd3: horner_div = DVSR_W'(20);
      4'd4: horner_div = DVSR_W'(6);
      4'd8: horner_div = DVSR_W'(132);
      4'd9: horner_div = DVSR_W'(90);
      4'd10: horner_div = DVSR_W'(56);
      4'd11: horner_div = DVSR_W'(30);
      4'd12: horner_div = DVSR_W'(12);
      default: horner_div = DVSR_W'(1);
    endcase
  endfunction

  // Apply sign to a micrometre magnitude and saturate to the output range.
  function automatic logic signed [OUT_W-1:0] sat_um(input logic neg, input logic [DIV_W-1:0] q);
    logic [OUT_W-1:0] low;
    low = q[OUT_W-1:0];
    if (!neg) begin
      sat_um = (q > OUT_POS) ? OUT_POS[OUT_W-1:0] : low;
    end else begin
      sat_um = (q > (OUT_POS + 64'd1)) ? {1'b1, {(OUT_W-1){1'b0}}} : -low;
    end
  endfunction

endpackage

FILE: hdl/euler_rotated_dead_reckoning_top.sv
// Euler ZYX dead-reckoning integrator: sequencer around a shared multiplier and divider.
//
// Input channel: in_valid / in_stall carry one navigation sample per transaction
// (three Euler angles, body velocity, timestamp, altitude). in_stall is high
// while a sample is being processed; one sample is worked on at a time.
// Output channel: out_valid / out_stall carry one pose per transaction
// (x and y in micrometres, z copied from altitude, first-sample flag).
// Each sample is worked through on the shared divider: 35 divisions (Horner
// chains of sine and cosine for three angles, radian scaling, micrometre
// conversion), plus multiplier steps on the shared 34x34 multiplier.
// A finished pose waits in the output register while the next sample is taken;
// if the receiver still stalls when that next pose is ready, the sequencer
// holds it until the output register frees.
// Reset (synchronous) clears the accumulators, the previous timestamp and the
// first-sample history; the block is ready in the cycle after reset drops.
module euler_rotated_dead_reckoning_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [erdr_pkg::ANG_W-1:0]   roll_angle,
  input  logic signed [erdr_pkg::ANG_W-1:0]   pitch_angle,
  input  logic signed [erdr_pkg::ANG_W-1:0]   yaw_angle,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_x,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_y,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_z,
  input  logic [erdr_pkg::SEC_W-1:0]          stamp_seconds,
  input  logic [erdr_pkg::NS_W-1:0]           stamp_nanos,
  input  logic [erdr_pkg::ALT_W-1:0]          altitude_mm,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [erdr_pkg::OUT_W-1:0]   pos_x_um,
  output logic signed [erdr_pkg::OUT_W-1:0]   pos_y_um,
  output logic [erdr_pkg::ALT_W-1:0]          pos_z_mm,
  output logic                                first_sample
);
  import erdr_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'd20;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG, ST_RAD, ST_RAD_W, ST_SQ, ST_SQ_GET,
    ST_H_MUL, ST_H_DIV, ST_H_W, ST_S_MUL, ST_S_GET, ST_C_MUL, ST_C_GET,
    ST_M_ISS, ST_M_GET, ST_X_DIV, ST_X_W, ST_Y_DIV, ST_Y_W, ST_DONE
  } state_t;

  state_t state;

  logic signed [ANG_W-1:0]  ang_r [3];
  logic signed [VEL_W-1:0]  vel_r [3];
  logic [SEC_W-1:0]         sec_r;
  logic [NS_W-1:0]          ns_r;
  logic [ALT_W-1:0]         alt_r;

  logic                     have_previous;
  logic [SEC_W-1:0]         prev_seconds;
  logic [NS_W-1:0]          prev_nanos;
  logic [63:0]              accum_x;
  logic [63:0]              accum_y;

  logic [1:0]               ai;
  logic [1:0]               quad_r;
  logic [30:0]              r;
  logic [31:0]              r2;
  logic [30:0]              t;
  logic [30:0]              sv;
  logic [2:0]               j;
  logic                     cos_ph;
  logic signed [Q_W-1:0]    sn [3];
  logic signed [Q_W-1:0]    cs [3];
  logic signed [Q_W-1:0]    cysp;
  logic signed [Q_W-1:0]    sysp;
  logic signed [M_W-1:0]    tmp;
  logic signed [M_W-1:0]    m [6];
  logic signed [PROD_W-1:0] acc;
  logic signed [GV_W-1:0]   gx;
  logic signed [GV_W-1:0]   gy;
  logic [DT_W-1:0]          dt;
  logic [4:0]               step;
  logic                     first_r;
  logic signed [OUT_W-1:0]  px;
  logic signed [OUT_W-1:0]  py;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] p;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVSR_W-1:0]        div_divisor;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;

  logic [15:0]              a_mod;
  logic [1:0]               quad;
  logic [15:0]              rem_full;
  logic [12:0]              rem;
  logic signed [PROD_W-1:0] rq;
  logic signed [PROD_W-1:0] rq_acc;
  logic signed [M_W-1:0]    rq_m;
  logic signed [SEC_W:0]    sec_diff;
  logic signed [NS_W:0]     ns_diff;
  logic signed [PROD_W-1:0] dt_full;
  logic [DT_W-1:0]          dt_next;
  logic [30:0]              t_next;
  logic [30:0]              cos_d;
  logic [30:0]              cv;
  logic signed [Q_W-1:0]    s0;
  logic signed [Q_W-1:0]    c0;
  logic [63:0]              mag_x;
  logic [63:0]              mag_y;
  logic                     accept;
  logic                     out_free;

  erdr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  erdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Angle reduction into quadrant and remainder.
  always_comb begin
    a_mod = 16'(ang_r[ai]);
    if (ang_r[ai][ANG_W-1]) begin
      a_mod = a_mod + TURN_UNITS;
    end
    if (a_mod >= 16'(3 * QUARTER_UNITS)) begin
      quad = 2'd3;
      rem_full = a_mod - 16'(3 * QUARTER_UNITS);
    end else if (a_mod >= 16'(2 * QUARTER_UNITS)) begin
      quad = 2'd2;
      rem_full = a_mod - 16'(2 * QUARTER_UNITS);
    end else if (a_mod >= QUARTER_UNITS) begin
      quad = 2'd1;
      rem_full = a_mod - QUARTER_UNITS;
    end else begin
      quad = 2'd0;
      rem_full = a_mod;
    end
    rem = rem_full[12:0];
  end

  always_comb begin
    t_next = ONE_Q30 - div_q[30:0];
    cos_d = p[61:31];
    cv = (cos_d >= ONE_Q30) ? 31'd0 : ONE_Q30 - cos_d;
    s0 = to_frac(sv);
    c0 = to_frac(cv);
    rq = rnd_q(p);
    rq_m = M_W'(rq);
    rq_acc = rnd_q(acc + p);
    sec_diff = $signed({1'b0, sec_r}) - $signed({1'b0, prev_seconds});
    ns_diff = $signed({1'b0, ns_r}) - $signed({1'b0, prev_nanos});
    dt_full = p + PROD_W'(ns_diff);
    if (!have_previous || dt_full[PROD_W-1]) begin
      dt_next = '0;
    end else if (dt_full > PROD_W'(MAX_STEP_NS)) begin
      dt_next = DT_W'(MAX_STEP_NS);
    end else begin
      dt_next = dt_full[DT_W-1:0];
    end
    mag_x = accum_x[63] ? -accum_x : accum_x;
    mag_y = accum_y[63] ? -accum_y : accum_y;
  end

  // Shared unit operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_dividend = {{(DIV_W-32){1'b0}}, p[61:30]};
    div_divisor = horner_div(cos_ph, j);
    case (state)
      ST_ANG: begin
        mul_a = MUL_W'(rem);
        mul_b = MUL_W'(PI_Q30);
      end
      ST_RAD: begin
        div_start = 1'b1;
        div_dividend = p[DIV_W-1:0];
        div_divisor = HALF_UNITS;
      end
      ST_SQ: begin
        mul_a = MUL_W'(r);
        mul_b = MUL_W'(r);
      end
      ST_H_MUL, ST_C_MUL: begin
        mul_a = MUL_W'(r2);
        mul_b = MUL_W'(t);
      end
      ST_H_DIV: begin
        div_start = 1'b1;
      end
      ST_S_MUL: begin
        mul_a = MUL_W'(r);
        mul_b = MUL_W'(t);
      end
      ST_M_ISS: begin
        case (step)
          5'd0: begin mul_a = MUL_W'(cs[2]); mul_b = MUL_W'(sn[1]); end
          5'd1: begin mul_a = MUL_W'(sn[2]); mul_b = MUL_W'(sn[1]); end
          5'd2: begin mul_a = MUL_W'(cs[2]); mul_b = MUL_W'(cs[1]); end
          5'd3: begin mul_a = MUL_W'(cysp); mul_b = MUL_W'(sn[0]); end
          5'd4: begin mul_a = MUL_W'(sn[2]); mul_b = MUL_W'(cs[0]); end
          5'd5: begin mul_a = MUL_W'(cysp); mul_b = MUL_W'(cs[0]); end
          5'd6: begin mul_a = MUL_W'(sn[2]); mul_b = MUL_W'(sn[0]); end
          5'd7: begin mul_a = MUL_W'(sn[2]); mul_b = MUL_W'(cs[1]); end
          5'd8: begin mul_a = MUL_W'(sysp); mul_b = MUL_W'(sn[0]); end
          5'd9: begin mul_a = MUL_W'(cs[2]); mul_b = MUL_W'(cs[0]); end
          5'd10: begin mul_a = MUL_W'(sysp); mul_b = MUL_W'(cs[0]); end
          5'd11: begin mul_a = MUL_W'(cs[2]); mul_b = MUL_W'(sn[0]); end
          5'd12: begin mul_a = MUL_W'(m[0]); mul_b = MUL_W'(vel_r[0]); end
          5'd13: begin mul_a = MUL_W'(m[1]); mul_b = MUL_W'(vel_r[1]); end
          5'd14: begin mul_a = MUL_W'(m[2]); mul_b = MUL_W'(vel_r[2]); end
          5'd15: begin mul_a = MUL_W'(m[3]); mul_b = MUL_W'(vel_r[0]); end
          5'd16: begin mul_a = MUL_W'(m[4]); mul_b = MUL_W'(vel_r[1]); end
          5'd17: begin mul_a = MUL_W'(m[5]); mul_b = MUL_W'(vel_r[2]); end
          5'd18: begin mul_a = MUL_W'(sec_diff); mul_b = MUL_W'(NS_PER_SEC); end
          5'd19: begin mul_a = MUL_W'(gx); mul_b = MUL_W'(dt); end
          5'd20: begin mul_a = MUL_W'(gy); mul_b = MUL_W'(dt); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_X_DIV: begin
        div_start = 1'b1;
        div_dividend = mag_x;
        div_divisor = NS_PER_UM;
      end
      ST_Y_DIV: begin
        div_start = 1'b1;
        div_dividend = mag_y;
        div_divisor = NS_PER_UM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      have_previous <= 1'b0;
      prev_seconds <= '0;
      prev_nanos <= '0;
      accum_x <= '0;
      accum_y <= '0;
      ai <= '0;
      j <= '0;
      cos_ph <= 1'b0;
      step <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ang_r[0] <= roll_angle;
            ang_r[1] <= pitch_angle;
            ang_r[2] <= yaw_angle;
            vel_r[0] <= body_vel_x;
            vel_r[1] <= body_vel_y;
            vel_r[2] <= body_vel_z;
            sec_r <= stamp_seconds;
            ns_r <= stamp_nanos;
            alt_r <= altitude_mm;
            ai <= '0;
            state <= ST_ANG;
          end
        end
        ST_ANG: begin
          quad_r <= quad;
          state <= ST_RAD;
        end
        ST_RAD: state <= ST_RAD_W;
        ST_RAD_W: begin
          if (div_done) begin
            r <= div_q[30:0];
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SQ_GET;
        ST_SQ_GET: begin
          r2 <= p[61:30];
          t <= ONE_Q30;
          j <= '0;
          cos_ph <= 1'b0;
          state <= ST_H_MUL;
        end
        ST_H_MUL: state <= ST_H_DIV;
        ST_H_DIV: state <= ST_H_W;
        ST_H_W: begin
          if (div_done) begin
            t <= t_next;
            if (j == 3'(TERMS - 1)) begin
              state <= cos_ph ? ST_C_MUL : ST_S_MUL;
            end else begin
              j <= j + 3'd1;
              state <= ST_H_MUL;
            end
          end
        end
        ST_S_MUL: state <= ST_S_GET;
        ST_S_GET: begin
          sv <= p[60:30];
          t <= ONE_Q30;
          j <= '0;
          cos_ph <= 1'b1;
          state <= ST_H_MUL;
        end
        ST_C_MUL: state <= ST_C_GET;
        ST_C_GET: begin
          case (quad_r)
            2'd0: begin sn[ai] <= s0; cs[ai] <= c0; end
            2'd1: begin sn[ai] <= c0; cs[ai] <= -s0; end
            2'd2: begin sn[ai] <= -s0; cs[ai] <= -c0; end
            default: begin sn[ai] <= -c0; cs[ai] <= s0; end
          endcase
          if (ai == 2'd2) begin
            step <= '0;
            state <= ST_M_ISS;
          end else begin
            ai <= ai + 2'd1;
            state <= ST_ANG;
          end
        end
        ST_M_ISS: state <= ST_M_GET;
        ST_M_GET: begin
          case (step)
            5'd0: cysp <= Q_W'(rq);
            5'd1: sysp <= Q_W'(rq);
            5'd2: m[0] <= rq_m;
            5'd3, 5'd5, 5'd8, 5'd10: tmp <= rq_m;
            5'd4: m[1] <= tmp - rq_m;
            5'd6: m[2] <= tmp + rq_m;
            5'd7: m[3] <= rq_m;
            5'd9: m[4] <= tmp + rq_m;
            5'd11: m[5] <= tmp - rq_m;
            5'd12, 5'd15: acc <= p;
            5'd13, 5'd16: acc <= acc + p;
            5'd14: gx <= GV_W'(rq_acc);
            5'd17: gy <= GV_W'(rq_acc);
            5'd18: begin
              dt <= dt_next;
              first_r <= !have_previous;
              have_previous <= 1'b1;
              prev_seconds <= sec_r;
              prev_nanos <= ns_r;
            end
            5'd19: accum_x <= accum_x + p[63:0];
            5'd20: accum_y <= accum_y + p[63:0];
            default: acc <= acc;
          endcase
          if (step == LAST_STEP) begin
            state <= ST_X_DIV;
          end else begin
            step <= step + 5'd1;
            state <= ST_M_ISS;
          end
        end
        ST_X_DIV: state <= ST_X_W;
        ST_X_W: begin
          if (div_done) begin
            px <= sat_um(accum_x[63], div_q);
            state <= ST_Y_DIV;
          end
        end
        ST_Y_DIV: state <= ST_Y_W;
        ST_Y_W: begin
          if (div_done) begin
            py <= sat_um(accum_y[63], div_q);
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pos_x_um <= px;
            pos_y_um <= py;
            pos_z_mm <= alt_r;
            first_sample <= first_r;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block ready right after taking a transaction");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_RAD_W || state == ST_H_W || state == ST_X_W ||
                  state == ST_Y_W))
    else $error("divider finished outside a wait state");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not posted");

endmodule

FILE: hdl/erdr_mul.sv
// Shared signed multiplier with a registered product.
module erdr_mul (
  input  logic                                clk,
  input  logic signed [erdr_pkg::MUL_W-1:0]   a,
  input  logic signed [erdr_pkg::MUL_W-1:0]   b,
  output logic signed [erdr_pkg::PROD_W-1:0]  p
);
  import erdr_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: hdl/erdr_div.sv
// Iterative unsigned divider, several quotient bits per cycle.
module erdr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [erdr_pkg::DIV_W-1:0]        dividend,
  input  logic [erdr_pkg::DVSR_W-1:0]       divisor,
  output logic                              done,
  output logic [erdr_pkg::DIV_W-1:0]        quotient
);
  import erdr_pkg::*;

  localparam int CNT_W = $clog2(DIV_CYCLES);

  logic [DIV_W-1:0]  qr;
  logic [DVSR_W:0]   rem;
  logic [DVSR_W-1:0] dvsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIV_W-1:0]  qr_next;
  logic [DVSR_W:0]   rem_next;

  always_comb begin
    qr_next = qr;
    rem_next = rem;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      rem_next = {rem_next[DVSR_W-1:0], qr_next[DIV_W-1]};
      qr_next = {qr_next[DIV_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvsr}) begin
        rem_next = rem_next - {1'b0, dvsr};
        qr_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr <= dividend;
      rem <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      qr <= qr_next;
      rem <= rem_next;
    end
  end

  assign quotient = qr;

endmodule

FILE: test/erdr_checker.sv
// Pose predictor and scoreboard for the Euler dead-reckoning integrator.
`timescale 1ns / 100ps
module erdr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [erdr_pkg::ANG_W-1:0]   roll_angle,
  input  logic signed [erdr_pkg::ANG_W-1:0]   pitch_angle,
  input  logic signed [erdr_pkg::ANG_W-1:0]   yaw_angle,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_x,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_y,
  input  logic signed [erdr_pkg::VEL_W-1:0]   body_vel_z,
  input  logic [erdr_pkg::SEC_W-1:0]          stamp_seconds,
  input  logic [erdr_pkg::NS_W-1:0]           stamp_nanos,
  input  logic [erdr_pkg::ALT_W-1:0]          altitude_mm,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [erdr_pkg::OUT_W-1:0]   pos_x_um,
  input  logic signed [erdr_pkg::OUT_W-1:0]   pos_y_um,
  input  logic [erdr_pkg::ALT_W-1:0]          pos_z_mm,
  input  logic                                first_sample,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  poses_checked,
  output int                                  clamped_steps
);
  import erdr_pkg::*;

  localparam longint FRAC = 15;
  localparam longint STEP_MAX = 64'd2147483647;
  localparam longint SEC_NS = 64'd1000000000;
  localparam longint POS_MAX = 64'd8796093022207;
  localparam bit [63:0] Q30_ONE = 64'd1073741824;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic [ALT_W-1:0]        z;
    logic                    first;
  } pose_t;

  pose_t pose_q[$];

  bit         seen_stamp;
  bit [31:0]  last_sec;
  bit [29:0]  last_ns;
  bit [63:0]  dist_x;
  bit [63:0]  dist_y;

  function automatic longint round_q(longint v);
    longint half;
    half = longint'(1) << (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -((-v + half) >>> FRAC);
  endfunction

  function automatic longint q30_frac(bit [63:0] q);
    if (q > Q30_ONE) q = Q30_ONE;
    return longint'((q + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  task automatic angle_trig(input longint ang, output longint s, output longint c);
    bit [63:0] sdiv [5];
    bit [63:0] cdiv [5];
    longint a;
    int quad;
    bit [63:0] r, r2, t, sv, cv, d;
    longint s0, c0;
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12};
    a = ang % 23040;
    if (a < 0) a += 23040;
    quad = int'(a / 5760);
    r = (64'(a % 5760) * 64'd3373259426) / 64'd11520;
    r2 = (r * r) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((r2 * t) >> 30) / sdiv[i];
    sv = (r * t) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((r2 * t) >> 30) / cdiv[i];
    d = ((r2 * t) >> 30) / 64'd2;
    cv = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    s0 = q30_frac(sv);
    c0 = q30_frac(cv);
    case (quad)
      0: begin s = s0; c = c0; end
      1: begin s = c0; c = -s0; end
      2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  function automatic logic signed [OUT_W-1:0] dist_to_um(bit [63:0] a);
    longint v;
    if (a[63]) v = -longint'((~a + 64'd1) / 64'd1000000);
    else v = longint'(a / 64'd1000000);
    if (v > POS_MAX) v = POS_MAX;
    if (v < -POS_MAX - 1) v = -POS_MAX - 1;
    return v[OUT_W-1:0];
  endfunction

  task automatic predict_pose();
    longint sr, cr, sp, cp, sy, cy, vx, vy, vz;
    longint cysp, sysp, m00, m01, m02, m10, m11, m12, gx, gy, dt;
    pose_t p;
    angle_trig(longint'(roll_angle), sr, cr);
    angle_trig(longint'(pitch_angle), sp, cp);
    angle_trig(longint'(yaw_angle), sy, cy);
    vx = body_vel_x;
    vy = body_vel_y;
    vz = body_vel_z;
    cysp = round_q(cy * sp);
    sysp = round_q(sy * sp);
    m00 = round_q(cy * cp);
    m01 = round_q(cysp * sr) - round_q(sy * cr);
    m02 = round_q(cysp * cr) + round_q(sy * sr);
    m10 = round_q(sy * cp);
    m11 = round_q(sysp * sr) + round_q(cy * cr);
    m12 = round_q(sysp * cr) - round_q(cy * sr);
    gx = round_q(m00 * vx + m01 * vy + m02 * vz);
    gy = round_q(m10 * vx + m11 * vy + m12 * vz);
    dt = 0;
    p.first = !seen_stamp;
    if (seen_stamp) begin
      dt = (longint'(stamp_seconds) - longint'(last_sec)) * SEC_NS
         + (longint'(stamp_nanos) - longint'(last_ns));
      if (dt < 0 || dt > STEP_MAX) clamped_steps++;
      if (dt < 0) dt = 0;
      if (dt > STEP_MAX) dt = STEP_MAX;
    end
    seen_stamp = 1'b1;
    last_sec = stamp_seconds;
    last_ns = stamp_nanos;
    dist_x = dist_x + 64'(gx * dt);
    dist_y = dist_y + 64'(gy * dt);
    p.x = dist_to_um(dist_x);
    p.y = dist_to_um(dist_y);
    p.z = altitude_mm;
    pose_q.push_back(p);
  endtask

  assign pending = pose_q.size();

  initial begin
    fail_count = 0;
    poses_checked = 0;
    clamped_steps = 0;
  end

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      seen_stamp <= 1'b0;
      last_sec <= '0;
      last_ns <= '0;
      dist_x <= '0;
      dist_y <= '0;
      pose_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_pose();
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $error("pose transaction with nothing expected");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          poses_checked++;
          if (pos_x_um !== e.x) begin
            $error("pos_x_um expected %0d actual %0d", e.x, pos_x_um);
            fail_count++;
          end
          if (pos_y_um !== e.y) begin
            $error("pos_y_um expected %0d actual %0d", e.y, pos_y_um);
            fail_count++;
          end
          if (pos_z_mm !== e.z) begin
            $error("pos_z_mm expected %0d actual %0d", e.z, pos_z_mm);
            fail_count++;
          end
          if (first_sample !== e.first) begin
            $error("first_sample expected %0d actual %0d", e.first, first_sample);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

FILE: test/testbench.sv
// Stimulus and verdict for the Euler dead-reckoning integrator.
`timescale 1ns / 100ps
module testbench;
  import erdr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANG_W-1:0] roll_angle = '0;
  logic signed [ANG_W-1:0] pitch_angle = '0;
  logic signed [ANG_W-1:0] yaw_angle = '0;
  logic signed [VEL_W-1:0] body_vel_x = '0;
  logic signed [VEL_W-1:0] body_vel_y = '0;
  logic signed [VEL_W-1:0] body_vel_z = '0;
  logic [SEC_W-1:0] stamp_seconds = '0;
  logic [NS_W-1:0] stamp_nanos = '0;
  logic [ALT_W-1:0] altitude_mm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] pos_x_um;
  logic signed [OUT_W-1:0] pos_y_um;
  logic [ALT_W-1:0] pos_z_mm;
  logic first_sample;

  int fail_count, pending, poses_checked, clamped_steps;
  int samples_sent = 0;
  bit sender_busy = 1'b1;
  bit calm_phase = 1'b0;
  bit [31:0] cur_sec = 32'd100;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_rotated_dead_reckoning_top u_dut (.*);

  erdr_checker u_checker (.*);

  task automatic send_sample(input int r, input int p, input int y, input int vx, input int vy,
                             input int vz, input bit [31:0] sec, input bit [29:0] ns,
                             input bit [15:0] alt);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    roll_angle <= ANG_W'(r);
    pitch_angle <= ANG_W'(p);
    yaw_angle <= ANG_W'(y);
    body_vel_x <= VEL_W'(vx);
    body_vel_y <= VEL_W'(vy);
    body_vel_z <= VEL_W'(vz);
    stamp_seconds <= sec;
    stamp_nanos <= ns;
    altitude_mm <= alt;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    samples_sent++;
  endtask

  function automatic int rand_angle();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 32767)) - 16384;
    return int'($urandom_range(0, 23040)) - 11520;
  endfunction

  function automatic int rand_vel();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    int k;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && poses_checked >= 120) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
      end
      k = calm_phase ? 0 : $urandom_range(0, 8);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    bit [29:0] ns;
    int u;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: first sample, angle and velocity extremes, time corner cases
    send_sample(0, 0, 0, 32767, 0, 0, 32'd100, 30'd0, 16'd0);
    send_sample(11520, -11520, 5760, -32768, 32767, -32768, 32'd100, 30'd500000000, 16'd65535);
    send_sample(-11520, 11520, -5760, 32767, -32768, 32767, 32'd101, 30'd0, 16'd1);
    send_sample(5760, 5759, 5761, 1000, 1000, 1000, 32'd101, 30'd100, 16'd2);
    send_sample(-16384, 16383, 11519, -1, 1, -1, 32'd99, 30'd0, 16'd3);
    send_sample(16383, -16384, -11519, 32767, 32767, 32767, 32'd105, 30'd0, 16'd4);
    send_sample(23, -17280, 17280, -32768, -32768, -32768, 32'd105, 30'h3FFFFFFF, 16'd5);
    send_sample(2880, 2880, 2880, 5000, -5000, 0, 32'd106, 30'd999999999, 16'd6);
    send_sample(-2880, 8640, -8640, 0, 0, 32767, 32'hFFFFFFFF, 30'd0, 16'd7);
    send_sample(0, 0, 0, 32767, 32767, 0, 32'hFFFFFFFF, 30'd2147483, 16'd8);
    send_sample(0, 0, 11520, 32767, 0, 0, 32'd0, 30'd0, 16'hAAAA);
    send_sample(1, -1, 11521, -32768, 1, 2, 32'd0, 30'd1, 16'h5555);
    cur_sec = 32'd0;
    for (int i = 0; i < 800; i++) begin
      calm_phase = (i >= 300 && i < 380);
      u = $urandom_range(0, 99);
      if (u < 4) cur_sec = $urandom;
      else if (u < 8) cur_sec = cur_sec - $urandom_range(0, 2);
      else cur_sec = cur_sec + $urandom_range(0, 2);
      ns = ($urandom_range(0, 99) < 8) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
      send_sample(rand_angle(), rand_angle(), rand_angle(), rand_vel(), rand_vel(), rand_vel(),
                  cur_sec, ns, 16'($urandom));
    end
    in_valid <= 1'b0;
    sender_busy = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    $display("%0d samples sent, %0d poses checked, %0d time steps clamped", samples_sent,
             poses_checked, clamped_steps);
    $display("covered angle wrap, velocity extremes, backward and oversized steps");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end
endmodule
